### hw/rtl/psq_pkg.sv
// ----------------------------------------------------------------------------
// psq_pkg
// Shared types and codes for the priority quantum scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package psq_pkg;

    localparam int IdWidth   = 8;
    localparam int TimeWidth = 16;
    localparam int PrioWidth = 8;
    localparam int LatWidth  = 32;

    typedef struct packed {
        logic [LatWidth-1:0]  lat;
        logic [PrioWidth-1:0] prio;
        logic [TimeWidth-1:0] rem;
        logic [IdWidth-1:0]   id;
    } t_slot;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_RUN = 1'b1;

    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RAN   = 2'd2;
    localparam logic [1:0] ST_IDLE  = 2'd3;

endpackage

`default_nettype wire

### hw/rtl/psq_cell.sv
// ----------------------------------------------------------------------------
// psq_cell
// One process slot of the rotating slot ring.
// ----------------------------------------------------------------------------
`default_nettype none

module psq_cell (
    input  wire           i_clk,
    input  wire           i_shift,
    input  psq_pkg::t_slot i_d,
    input  wire           i_load,
    input  psq_pkg::t_slot i_load_d,
    output psq_pkg::t_slot o_q
);
    import psq_pkg::*;

    t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_load_d;
        end else if (i_shift) begin
            r_slot <= i_d;
        end
    end

    assign o_q = r_slot;

endmodule

`default_nettype wire

### hw/rtl/priority_quantum_scheduler_core.sv
// ----------------------------------------------------------------------------
// priority_quantum_scheduler_core
// Non-preemptive priority scheduler with a run quantum over a slot ring.
// ----------------------------------------------------------------------------
// Slots live in a ring of MAX_SLOTS cells that rotates one place per cycle
// while a run is in its scan or update state. An add transaction writes the
// next free cell directly and goes through the finish state to its result.
// A run transaction rotates the ring twice: one full turn to find the
// highest-priority slot, one turn to charge the quantum and update latencies
// as slots pass the head. One transaction is processed at a time; a result
// waits in the output register until taken.
`default_nettype none

module priority_quantum_scheduler_core #(
    parameter int MAX_SLOTS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [15:0] i_cfg_wdata,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [31:0] i_s_axis_tdata,   // proc_id[7:0], run_time[23:8], prio[31:24]
    input  wire         i_s_axis_tuser,   // opcode
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // ran_id[7:0], time_left[23:8],
                                          // wait_total[55:24], finished[56]
    output logic [1:0]  o_m_axis_tuser    // status
);
    import psq_pkg::*;

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPD, S_FIN} t_state;

    t_state               r_state;
    logic [IW-1:0]        r_step;
    logic [CW-1:0]        r_count;
    logic [15:0]          r_quantum;
    logic [PrioWidth-1:0] r_best;
    logic [IW-1:0]        r_pick;
    logic [TimeWidth-1:0] r_bestrem;
    logic [1:0]           r_status;
    logic [IdWidth-1:0]   r_res_id;
    logic [TimeWidth-1:0] r_res_rem;
    logic [LatWidth-1:0]  r_res_lat;
    logic                 r_res_fin;

    t_slot ring [MAX_SLOTS];
    t_slot tail_d;
    t_slot head_n;
    t_slot new_slot;
    logic  accept;
    logic  do_add;
    logic  shift;
    logic  last_step;
    logic  in_use;
    logic [TimeWidth-1:0] charge;
    logic [LatWidth:0]    lat_sum;

    assign accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign do_add    = accept && (i_s_axis_tuser == OP_ADD) && (r_count < CW'(MAX_SLOTS));
    assign shift     = (r_state == S_SCAN) || (r_state == S_UPD);
    assign last_step = (r_step == IW'(MAX_SLOTS - 1));
    assign in_use    = CW'(r_step) < r_count;
    assign o_s_axis_tready = (r_state == S_IDLE);

    assign new_slot.id   = i_s_axis_tdata[7:0];
    assign new_slot.rem  = i_s_axis_tdata[23:8];
    assign new_slot.prio = i_s_axis_tdata[31:24];
    assign new_slot.lat  = '0;

    assign charge  = (r_quantum < r_bestrem) ? r_quantum : r_bestrem;
    assign lat_sum = {1'b0, ring[0].lat} + {{(LatWidth-TimeWidth+1){1'b0}}, charge};

    // update applied to the slot leaving the head during the second turn
    always_comb begin
        head_n = ring[0];
        if ((r_best != '0) && in_use) begin
            if (ring[0].prio != '0) begin
                head_n.lat = lat_sum[LatWidth] ? '1 : lat_sum[LatWidth-1:0];
            end
            if (r_step == r_pick) begin
                head_n.rem = ring[0].rem - charge;
                if (head_n.rem == '0) begin
                    head_n.prio = '0;
                end
            end
        end
    end

    assign tail_d = (r_state == S_UPD) ? head_n : ring[0];

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        psq_cell u_cell (
            .i_clk    (i_clk),
            .i_shift  (shift),
            .i_d      ((g == MAX_SLOTS - 1) ? tail_d : ring[(g + 1) % MAX_SLOTS]),
            .i_load   (do_add && (r_count == CW'(g))),
            .i_load_d (new_slot),
            .o_q      (ring[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_count         <= '0;
            r_quantum       <= 16'd10;
            r_step          <= '0;
            o_m_axis_tvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
            // the finish state reloads the output register itself
            if (o_m_axis_tvalid && i_m_axis_tready && (r_state != S_FIN)) begin
                o_m_axis_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res_id  <= '0;
                        r_res_rem <= '0;
                        r_res_lat <= '0;
                        r_res_fin <= 1'b0;
                        r_step    <= '0;
                        r_best    <= '0;
                        r_pick    <= '0;
                        r_bestrem <= '0;
                        if (i_s_axis_tuser == OP_RUN) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state  <= S_FIN;
                            r_status <= do_add ? ST_ADDED : ST_FULL;
                            if (do_add) begin
                                r_count <= r_count + 1'b1;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (in_use && (r_best < ring[0].prio) && (ring[0].rem != '0)) begin
                        r_best    <= ring[0].prio;
                        r_pick    <= r_step;
                        r_bestrem <= ring[0].rem;
                    end
                    r_step <= last_step ? '0 : r_step + 1'b1;
                    if (last_step) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if ((r_best != '0) && in_use && (r_step == r_pick)) begin
                        r_res_id  <= ring[0].id;
                        r_res_rem <= head_n.rem;
                        r_res_lat <= head_n.lat;
                        r_res_fin <= (head_n.rem == '0);
                    end
                    r_step <= last_step ? '0 : r_step + 1'b1;
                    if (last_step) begin
                        r_state  <= S_FIN;
                        r_status <= (r_best != '0) ? ST_RAN : ST_IDLE;
                    end
                end
                S_FIN: begin
                    if (!o_m_axis_tvalid || i_m_axis_tready) begin
                        o_m_axis_tvalid <= 1'b1;
                        o_m_axis_tuser  <= r_status;
                        o_m_axis_tdata  <= {7'd0, r_res_fin, r_res_lat, r_res_rem, r_res_id};
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SLOTS))
        else $error("slot count beyond table size");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state) == S_FIN)
        else $error("result issued outside finish state");

    a_scan_to_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && last_step) |=> r_state == S_UPD && r_step == '0)
        else $error("scan turn did not hand over to update turn");

endmodule

`default_nettype wire

### bench/priority_quantum_scheduler_checker.sv
// ----------------------------------------------------------------------------
// priority_quantum_scheduler_checker
// Watches both streams of the scheduler core, predicts each result from a
// private copy of the slot table and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_quantum_scheduler_checker #(
    parameter int MAX_SLOTS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [15:0] i_cfg_wdata,
    input  wire         i_s_axis_tvalid,
    input  wire         i_s_axis_tready,
    input  wire  [31:0] i_s_axis_tdata,
    input  wire         i_s_axis_tuser,
    input  wire         i_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    input  wire  [63:0] i_m_axis_tdata,
    input  wire  [1:0]  i_m_axis_tuser,
    output int          o_fail_count,
    output int          o_pending
);
    import psq_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic        finished;
        logic [31:0] wait_total;
        logic [15:0] time_left;
        logic [7:0]  ran_id;
    } t_sched_result;

    logic [15:0]   quantum;
    t_slot         table_q [MAX_SLOTS];
    int            occupied;
    t_sched_result expected_results[$];

    function automatic t_sched_result schedule_step(input logic op, input logic [31:0] data);
        t_sched_result r;
        logic [7:0]    best;
        int            pick;
        logic [15:0]   charge;
        logic [32:0]   sum;
        r = '0;
        best = '0;
        pick = 0;
        if (op == OP_ADD) begin
            if (occupied >= MAX_SLOTS) begin
                r.status = ST_FULL;
            end else begin
                table_q[occupied].id   = data[7:0];
                table_q[occupied].rem  = data[23:8];
                table_q[occupied].prio = data[31:24];
                table_q[occupied].lat  = '0;
                occupied++;
                r.status = ST_ADDED;
            end
            return r;
        end
        for (int i = 0; i < occupied; i++) begin
            if (table_q[i].prio > best && table_q[i].rem != 0) begin
                best = table_q[i].prio;
                pick = i;
            end
        end
        if (best == 0) begin
            r.status = ST_IDLE;
            return r;
        end
        charge = (quantum < table_q[pick].rem) ? quantum : table_q[pick].rem;
        table_q[pick].rem -= charge;
        for (int i = 0; i < occupied; i++) begin
            if (table_q[i].prio != 0) begin
                sum = {1'b0, table_q[i].lat} + charge;
                table_q[i].lat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
        end
        if (table_q[pick].rem == 0) table_q[pick].prio = '0;
        r.status     = ST_RAN;
        r.ran_id     = table_q[pick].id;
        r.time_left  = table_q[pick].rem;
        r.wait_total = table_q[pick].lat;
        r.finished   = (table_q[pick].rem == 0);
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_sched_result want;
        t_sched_result got;
        if (!i_rst_n) begin
            quantum      <= 16'd10;
            occupied     = 0;
            o_fail_count <= 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) quantum <= i_cfg_wdata;
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_results.push_back(schedule_step(i_s_axis_tuser, i_s_axis_tdata));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.status     = i_m_axis_tuser;
                got.ran_id     = i_m_axis_tdata[7:0];
                got.time_left  = i_m_axis_tdata[23:8];
                got.wait_total = i_m_axis_tdata[55:24];
                got.finished   = i_m_axis_tdata[56];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== got) begin
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

### bench/priority_quantum_scheduler_core_test.sv
// ----------------------------------------------------------------------------
// priority_quantum_scheduler_core_test
// Drives adds and run ticks through several quantum settings, with bursty
// input and a stalling output, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_quantum_scheduler_core_test;
    import psq_pkg::*;

    localparam int MAX_SLOTS   = 16;
    localparam int IDLE_LIMIT  = 5000;
    localparam int DRAIN_WAIT  = 2 * MAX_SLOTS + 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    wire         in_ready;
    logic [31:0] in_data;
    logic        in_op;
    wire         out_valid;
    logic        out_ready;
    wire  [63:0] out_data;
    wire  [1:0]  out_status;
    int          fail_count;
    int          pending;
    int          quiet_cycles;
    bit          hold_long;

    priority_quantum_scheduler_core #(.MAX_SLOTS(MAX_SLOTS)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_s_axis_tvalid(in_valid),
        .o_s_axis_tready(in_ready),
        .i_s_axis_tdata (in_data),
        .i_s_axis_tuser (in_op),
        .o_m_axis_tvalid(out_valid),
        .i_m_axis_tready(out_ready),
        .o_m_axis_tdata (out_data),
        .o_m_axis_tuser (out_status)
    );

    priority_quantum_scheduler_checker #(.MAX_SLOTS(MAX_SLOTS)) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_s_axis_tvalid(in_valid),
        .i_s_axis_tready(in_ready),
        .i_s_axis_tdata (in_data),
        .i_s_axis_tuser (in_op),
        .i_m_axis_tvalid(out_valid),
        .i_m_axis_tready(out_ready),
        .i_m_axis_tdata (out_data),
        .i_m_axis_tuser (out_status),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: own stall pattern, plus one long hold-off on request
    initial begin
        int phase;
        out_ready = 1'b0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                out_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_long = 1'b0;
            end
            phase++;
            if ((phase / 200) % 3 == 2) out_ready <= 1'b1;
            else out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_item(input logic op, input logic [7:0] id,
                             input logic [15:0] rt, input logic [7:0] pr);
        in_valid <= 1'b1;
        in_op    <= op;
        in_data  <= {pr, rt, id};
        // ready follows block state only, so it is settled at the falling edge
        while (!in_ready) @(negedge i_clk);
        @(negedge i_clk);
        // random gap between bursts
        if ($urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge i_clk);
        end
    endtask

    task automatic drain_and_set(input logic [15:0] q);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= q;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // a table fill: MAX_SLOTS adds, then a run of ticks mixed with occasional adds
    task automatic random_table(input int runs);
        logic [15:0] rt;
        logic [7:0]  pr;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            rt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
            pr = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            send_item(OP_ADD, 8'($urandom), rt, pr);
        end
        for (int i = 0; i < runs; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(OP_ADD, 8'($urandom), 16'($urandom), 8'($urandom));
            else
                send_item(OP_RUN, 8'($urandom), 16'($urandom), 8'($urandom));
        end
    endtask

    task automatic reset_block();
        in_valid <= 1'b0;
        i_rst_n  <= 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        in_op     = OP_ADD;
        hold_long = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: idle on empty table, extremes, zero prio and zero time
        send_item(OP_RUN, 8'h00, 16'h0000, 8'h00);
        send_item(OP_ADD, 8'hFF, 16'hFFFF, 8'hFF);
        send_item(OP_ADD, 8'h00, 16'h0000, 8'h80);
        send_item(OP_ADD, 8'h5A, 16'h0005, 8'h00);
        send_item(OP_ADD, 8'hA5, 16'h0003, 8'hFF);
        send_item(OP_ADD, 8'h11, 16'h0001, 8'h01);
        for (int i = 0; i < 6; i++) send_item(OP_RUN, 8'hFF, 16'hFFFF, 8'hFF);
        drain_and_set(16'hFFFF);
        for (int i = 0; i < 3; i++) send_item(OP_RUN, 8'h00, 16'h0000, 8'h00);
        // fill to full, then overflow add
        for (int i = 0; i < 11; i++) send_item(OP_ADD, 8'(i), 16'hFFFF, 8'h7F);
        send_item(OP_ADD, 8'hEE, 16'h1234, 8'h44);
        drain_and_set(16'd1);
        send_item(OP_RUN, 8'h00, 16'h0000, 8'h00);

        // random phases over several quantum settings; one block reset only
        // at start, so the table stays full and later phases exercise runs
        drain_and_set(16'd10);
        random_table(60);
        hold_long = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item(OP_RUN, 8'($urandom), 16'($urandom), 8'($urandom));
        drain_and_set(16'($urandom_range(1, 65535)));
        random_table(80);
        drain_and_set(16'd1);
        random_table(80);
        drain_and_set(16'hFFFF);
        random_table(60);
        drain_and_set(16'($urandom_range(1, 30)));
        random_table(60);

        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/psq_pkg.sv
hw/rtl/psq_cell.sv
hw/rtl/priority_quantum_scheduler_core.sv
bench/priority_quantum_scheduler_checker.sv
bench/priority_quantum_scheduler_core_test.sv
